[design/ntt_pkg.sv]
package ntt_pkg;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic [1:0] REG_FULL_TURN       = 2'd0;
   localparam logic [1:0] REG_WRAP_MARGIN     = 2'd1;
   localparam logic [1:0] REG_SAME_TARGET_GAP = 2'd2;
   localparam logic [1:0] REG_DISTANCE_LIMIT  = 2'd3;

   localparam logic [11:0] RST_FULL_TURN       = 12'd1300;
   localparam logic [11:0] RST_WRAP_MARGIN     = 12'd150;
   localparam logic [11:0] RST_SAME_TARGET_GAP = 12'd150;
   localparam logic [12:0] RST_DISTANCE_LIMIT  = 13'd1000;

   typedef struct packed {
      logic [1:0]  command;
      logic [11:0] step_angle;
      logic [12:0] distance_mm;
      logic        heading_to_target;
      logic [3:0]  entry_index;
   } ntt_req_type;

   typedef struct packed {
      logic [12:0] entry_distance;
      logic [11:0] entry_orientation;
      logic [11:0] entry_saved_orientation;
      logic [4:0]  valid_count;
      logic [11:0] least_orientation;
   } ntt_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic clear;
      logic sweep_init;
      logic sweep_step;
      logic sort_init;
      logic sort_by_orient;
      logic sort_step;
      logic offer;
      logic load_out;
   } ntt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_clear;
      logic is_sample;
      logic sample_ok;
      logic before_edge;
      logic at_edge;
      logic near_last;
      logic least_below_margin;
      logic ptr_last;
      logic sort_done;
   } ntt_stat_type;

endpackage

[design/nearest_target_table_unit.sv]
// Nearest target table: keeps the nearest range-sensor targets of a scan.
// Request channel (req_valid / req_stall / req_data) carries one command:
// clear the table, offer a scan sample, or read an entry. Every accepted
// transaction returns exactly one response on rsp_valid / rsp_stall /
// rsp_data: the entry picked by entry_index, the valid-target count and the
// least stored orientation, all taken after the command has run.
// The block handles one transaction at a time; req_stall is high from the
// accept until the response is loaded into the output register, so the next
// transaction is accepted at the earliest in the cycle after that load.
// A read, clear or rejected sample runs decode, a sweep over every entry
// and done. An accepted sample adds an offer step, plus a selection sort
// (one compare of the shared entry read port per cycle) unless it lands
// next to the last entry. A sample past the end-of-turn edge first adds a
// sweep for the least orientation and a decision step. A response waiting
// under rsp_stall blocks only the load of the next one. Configuration
// registers are written through csr_we / csr_index / csr_wdata; the user
// must write them only while idle, the block does not enforce it. Reset
// (synchronous) clears the table to its empty markers and the registers to
// their defaults, and drops rsp_valid.
module nearest_target_table_unit import ntt_pkg::*; #(
   parameter int NUM_TARGETS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ntt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ntt_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   ntt_cmd_type  cmd;
   ntt_stat_type stat;

   ntt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ntt_datapath #(.NUM_TARGETS(NUM_TARGETS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

[design/ntt_ctrl.sv]
module ntt_ctrl import ntt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  ntt_stat_type stat,
   output ntt_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_PRESWEEP = 3'd2;
   localparam logic [2:0] S_WRAP     = 3'd3;
   localparam logic [2:0] S_SORT     = 3'd4;
   localparam logic [2:0] S_OFFER    = 3'd5;
   localparam logic [2:0] S_SWEEP    = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_clear) begin
               cmd.clear      = 1'b1;
               cmd.sweep_init = 1'b1;
               state_in       = S_SWEEP;
            end else if (stat.is_sample && stat.sample_ok && stat.before_edge) begin
               if (!stat.near_last) begin
                  cmd.sort_init = 1'b1;
                  state_in      = S_SORT;
               end else begin
                  state_in = S_OFFER;
               end
            end else if (stat.is_sample && stat.sample_ok && !stat.at_edge) begin
               cmd.sweep_init = 1'b1;
               state_in       = S_PRESWEEP;
            end else begin
               cmd.sweep_init = 1'b1;
               state_in       = S_SWEEP;
            end
         end
         S_PRESWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.ptr_last) state_in = S_WRAP;
         end
         S_WRAP: begin
            if (stat.least_below_margin) begin
               cmd.sort_init      = 1'b1;
               cmd.sort_by_orient = 1'b1;
               state_in           = S_SORT;
            end else if (!stat.near_last) begin
               cmd.sort_init = 1'b1;
               state_in      = S_SORT;
            end else begin
               state_in = S_OFFER;
            end
         end
         S_SORT: begin
            cmd.sort_step = 1'b1;
            if (stat.sort_done) state_in = S_OFFER;
         end
         S_OFFER: begin
            cmd.offer      = 1'b1;
            cmd.sweep_init = 1'b1;
            state_in       = S_SWEEP;
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.ptr_last) state_in = S_DONE;
         end
         S_DONE: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_DECODE))
      else $error("accepted transaction did not enter decode");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_out && rsp_valid_ff && rsp_stall))
      else $error("result loaded over a stalled transaction");

   a_sort_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SORT) |=> (state_ff == S_SORT || state_ff == S_OFFER))
      else $error("sort left to an unexpected state");

endmodule

[design/ntt_datapath.sv]
module ntt_datapath import ntt_pkg::*; #(
   parameter int NUM_TARGETS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  ntt_req_type  req_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_wdata,
   input  ntt_cmd_type  cmd,
   output ntt_stat_type stat,
   output ntt_rsp_type  rsp_data
);

   localparam int IW = $clog2(NUM_TARGETS);
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TARGETS - 1);
   localparam logic [IW-1:0] LAST_PASS = IW'(NUM_TARGETS - 2);

   logic [11:0] full_turn_ff, wrap_margin_ff, gap_ff;
   logic [12:0] dist_limit_ff;

   logic [12:0] td_ff [NUM_TARGETS];
   logic [11:0] to_ff [NUM_TARGETS];
   logic [11:0] so_ff [NUM_TARGETS];

   ntt_req_type item_ff;
   ntt_rsp_type rsp_ff;

   logic [IW-1:0] ptr_ff, j_ff, at_ff;
   logic [12:0]   best_key_ff, best_oth_ff;
   logic [12:0]   capd_ff;
   logic [11:0]   capo_ff;
   logic          by_orient_ff;

   logic [4:0]  count_ff;
   logic [11:0] least_ff;
   logic [12:0] sel_d_ff;
   logic [11:0] sel_o_ff, sel_s_ff;

   // read port at ptr
   logic [12:0] rd_d;
   logic [11:0] rd_o, rd_s;
   assign rd_d = td_ff[ptr_ff];
   assign rd_o = to_ff[ptr_ff];
   assign rd_s = so_ff[ptr_ff];

   // sample checks
   logic [11:0] o_last, ang_diff;
   logic [12:0] ang_plus_margin;
   assign o_last          = to_ff[NUM_TARGETS-1];
   assign ang_diff        = (item_ff.step_angle >= o_last) ? item_ff.step_angle - o_last
                                                           : o_last - item_ff.step_angle;
   assign ang_plus_margin = {1'b0, item_ff.step_angle} + {1'b0, wrap_margin_ff};

   always_comb begin
      stat.is_clear           = (item_ff.command == CMD_CLEAR);
      stat.is_sample          = (item_ff.command == CMD_SAMPLE);
      stat.sample_ok          = !item_ff.heading_to_target
                                && (item_ff.step_angle < full_turn_ff)
                                && (item_ff.distance_mm != 13'd0)
                                && (item_ff.distance_mm < dist_limit_ff);
      stat.before_edge        = ang_plus_margin < {1'b0, full_turn_ff};
      stat.at_edge            = ang_plus_margin == {1'b0, full_turn_ff};
      stat.near_last          = ang_diff < gap_ff;
      stat.least_below_margin = least_ff < wrap_margin_ff;
      stat.ptr_last           = (ptr_ff == LAST_IDX);
      stat.sort_done          = (ptr_ff == LAST_IDX) && (j_ff == LAST_PASS);
   end

   // sort compare on the entry under the pointer
   logic          mark_by;
   logic [12:0]   key_i, oth_i, best_n, oth_n, mark_key, mark_oth;
   logic [IW-1:0] at_n;
   logic          key_lt, pass_end;

   assign mark_by  = cmd.sort_init ? cmd.sort_by_orient : by_orient_ff;
   assign mark_key = mark_by ? {1'b0, full_turn_ff} : dist_limit_ff;
   assign mark_oth = mark_by ? dist_limit_ff : {1'b0, full_turn_ff};
   assign key_i    = by_orient_ff ? {1'b0, rd_o} : rd_d;
   assign oth_i    = by_orient_ff ? rd_d : {1'b0, rd_o};
   assign key_lt   = key_i < best_key_ff;
   assign best_n   = key_lt ? key_i : best_key_ff;
   assign oth_n    = key_lt ? oth_i : best_oth_ff;
   assign at_n     = key_lt ? ptr_ff : at_ff;
   assign pass_end = cmd.sort_step && (ptr_ff == LAST_IDX);

   logic [12:0] new_jd;
   logic [11:0] new_jo;
   assign new_jd = by_orient_ff ? oth_n : best_n;
   assign new_jo = by_orient_ff ? best_n[11:0] : oth_n[11:0];

   logic [IW-1:0] slot;
   assign slot = by_orient_ff ? '0 : LAST_IDX;

   logic [IW-1:0] j_next;
   assign j_next = j_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_turn_ff   <= RST_FULL_TURN;
         wrap_margin_ff <= RST_WRAP_MARGIN;
         gap_ff         <= RST_SAME_TARGET_GAP;
         dist_limit_ff  <= RST_DISTANCE_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FULL_TURN:       full_turn_ff   <= csr_wdata[11:0];
            REG_WRAP_MARGIN:     wrap_margin_ff <= csr_wdata[11:0];
            REG_SAME_TARGET_GAP: gap_ff         <= csr_wdata[11:0];
            REG_DISTANCE_LIMIT:  dist_limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < NUM_TARGETS; e++) begin
            td_ff[e] <= RST_DISTANCE_LIMIT;
            to_ff[e] <= RST_FULL_TURN;
            so_ff[e] <= 12'd0;
         end
      end else begin
         for (int e = 0; e < NUM_TARGETS; e++) begin
            if (cmd.clear) begin
               td_ff[e] <= dist_limit_ff;
               to_ff[e] <= full_turn_ff;
               so_ff[e] <= 12'd0;
            end else if (pass_end && IW'(e) == j_ff) begin
               td_ff[e] <= new_jd;
               to_ff[e] <= new_jo;
               so_ff[e] <= new_jo;
            end else if (pass_end && IW'(e) == at_n) begin
               td_ff[e] <= capd_ff;
               to_ff[e] <= capo_ff;
            end else if (cmd.offer && IW'(e) == slot
                         && item_ff.distance_mm < td_ff[e]) begin
               td_ff[e] <= item_ff.distance_mm;
               to_ff[e] <= item_ff.step_angle;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_ff      <= req_data;
         by_orient_ff <= 1'b0;
      end
      if (cmd.sort_init) by_orient_ff <= cmd.sort_by_orient;

      if (cmd.sweep_init || cmd.sort_init) ptr_ff <= '0;
      else if (pass_end) ptr_ff <= j_next;
      else if (cmd.sweep_step || cmd.sort_step) ptr_ff <= ptr_ff + 1'b1;

      // restart the running minimum at each pass
      if (cmd.sort_init) begin
         j_ff        <= '0;
         at_ff       <= '0;
         best_key_ff <= mark_key;
         best_oth_ff <= mark_oth;
      end else if (pass_end) begin
         j_ff        <= j_next;
         at_ff       <= j_next;
         best_key_ff <= mark_key;
         best_oth_ff <= mark_oth;
      end else if (cmd.sort_step) begin
         at_ff       <= at_n;
         best_key_ff <= best_n;
         best_oth_ff <= oth_n;
      end
      if (cmd.sort_step && ptr_ff == j_ff) begin
         capd_ff <= rd_d;
         capo_ff <= rd_o;
      end

      if (cmd.sweep_init) begin
         count_ff <= 5'd0;
         least_ff <= full_turn_ff;
         sel_d_ff <= 13'd0;
         sel_o_ff <= 12'd0;
         sel_s_ff <= 12'd0;
      end else if (cmd.sweep_step) begin
         if (rd_d < dist_limit_ff && rd_o < full_turn_ff) count_ff <= count_ff + 5'd1;
         if (rd_o < least_ff) least_ff <= rd_o;
         if (item_ff.entry_index == 4'(ptr_ff)) begin
            sel_d_ff <= rd_d;
            sel_o_ff <= rd_o;
            sel_s_ff <= rd_s;
         end
      end

      if (cmd.load_out) begin
         rsp_ff.entry_distance          <= sel_d_ff;
         rsp_ff.entry_orientation       <= sel_o_ff;
         rsp_ff.entry_saved_orientation <= sel_s_ff;
         rsp_ff.valid_count             <= count_ff;
         rsp_ff.least_orientation       <= least_ff;
      end
   end

   assign rsp_data = rsp_ff;

   a_sort_ptr: assert property (@(posedge clock) disable iff (reset)
      cmd.sort_step |-> (ptr_ff >= j_ff))
      else $error("sort pointer behind pass position");

   a_pass_advance: assert property (@(posedge clock) disable iff (reset)
      (pass_end && !stat.sort_done) |=> (ptr_ff == j_ff && at_ff == j_ff))
      else $error("sort pass did not restart at its position");

   a_clear_decoded: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> stat.is_clear)
      else $error("table cleared for a transaction that is not a clear");

endmodule

[test/tb_nearest_target_table_unit.sv]
module tb_nearest_target_table_unit;
   import ntt_pkg::*;

   localparam int NT = 4;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      ntt_req_type item;
      logic        has_exp;
      ntt_rsp_type exp;
   } stim_row_type;

   localparam ntt_rsp_type EMPTY_ENTRY  = '{13'd1000, 12'd1300, 12'd0, 5'd0, 12'd1300};
   localparam ntt_rsp_type OUT_OF_RANGE = '{13'd0, 12'd0, 12'd0, 5'd0, 12'd1300};
   localparam ntt_rsp_type NO_CHECK     = '0;

   localparam int DIRECTED_COUNT = 24;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{CMD_READ,   12'd0,    13'd0,    1'b0, 4'd0},  1'b1, EMPTY_ENTRY},
      '{'{CMD_READ,   12'd0,    13'd0,    1'b0, 4'd15}, 1'b1, OUT_OF_RANGE},
      '{'{CMD_UNUSED, 12'd0,    13'd0,    1'b0, 4'd1},  1'b1, EMPTY_ENTRY},
      // rejected samples: heading, angle out of turn, distance zero or at limit, edge angle
      '{'{CMD_SAMPLE, 12'd100,  13'd500,  1'b1, 4'd3},  1'b1, EMPTY_ENTRY},
      '{'{CMD_SAMPLE, 12'd1300, 13'd500,  1'b0, 4'd0},  1'b1, EMPTY_ENTRY},
      '{'{CMD_SAMPLE, 12'd4095, 13'd8191, 1'b0, 4'd2},  1'b1, EMPTY_ENTRY},
      '{'{CMD_SAMPLE, 12'd200,  13'd0,    1'b0, 4'd1},  1'b1, EMPTY_ENTRY},
      '{'{CMD_SAMPLE, 12'd200,  13'd1000, 1'b0, 4'd0},  1'b1, EMPTY_ENTRY},
      '{'{CMD_SAMPLE, 12'd1150, 13'd500,  1'b0, 4'd3},  1'b1, EMPTY_ENTRY},
      // fill the table
      '{'{CMD_SAMPLE, 12'd0,    13'd1,    1'b0, 4'd3},  1'b0, NO_CHECK},
      '{'{CMD_SAMPLE, 12'd100,  13'd999,  1'b0, 4'd3},  1'b0, NO_CHECK},
      '{'{CMD_SAMPLE, 12'd400,  13'd300,  1'b0, 4'd2},  1'b0, NO_CHECK},
      '{'{CMD_SAMPLE, 12'd800,  13'd200,  1'b0, 4'd1},  1'b0, NO_CHECK},
      '{'{CMD_SAMPLE, 12'd999,  13'd999,  1'b0, 4'd0},  1'b0, NO_CHECK},
      // past the edge with a target near zero: merge
      '{'{CMD_SAMPLE, 12'd1200, 13'd100,  1'b0, 4'd0},  1'b0, NO_CHECK},
      '{'{CMD_SAMPLE, 12'd1299, 13'd50,   1'b0, 4'd0},  1'b0, NO_CHECK},
      '{'{CMD_READ,   12'd0,    13'd0,    1'b0, 4'd1},  1'b0, NO_CHECK},
      '{'{CMD_READ,   12'd0,    13'd0,    1'b0, 4'd2},  1'b0, NO_CHECK},
      '{'{CMD_READ,   12'd0,    13'd0,    1'b0, 4'd3},  1'b0, NO_CHECK},
      '{'{CMD_SAMPLE, 12'd1151, 13'd998,  1'b0, 4'd8},  1'b0, NO_CHECK},
      '{'{CMD_CLEAR,  12'd0,    13'd0,    1'b0, 4'd0},  1'b1, EMPTY_ENTRY},
      '{'{CMD_READ,   12'd0,    13'd0,    1'b0, 4'd4},  1'b1, OUT_OF_RANGE},
      '{'{CMD_SAMPLE, 12'd4095, 13'd8191, 1'b1, 4'd15}, 1'b1, OUT_OF_RANGE},
      '{'{CMD_READ,   12'd4095, 13'd8191, 1'b1, 4'd0},  1'b1, EMPTY_ENTRY}
   };

   localparam int PHASE_COUNT = 7;
   // full_turn, wrap_margin, same_target_gap, distance_limit, items
   localparam int PHASE_CFG [PHASE_COUNT][5] = '{
      '{1300, 150,  150,  1000, 85},
      '{4095, 0,    0,    8191, 85},
      '{1,    4095, 4095, 1,    20},
      '{360,  40,   20,   300,  85},
      '{2000, 4095, 300,  2000, 80},
      '{-1,   -1,   -1,   -1,   85},
      '{800,  100,  60,   4000, 85}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ntt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ntt_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_FULL_TURN;
   logic [12:0] csr_wdata = '0;

   nearest_target_table_unit #(.NUM_TARGETS(NT)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // shadow of the table and its registers
   logic [11:0] turn_steps = RST_FULL_TURN;
   logic [11:0] wrap_band = RST_WRAP_MARGIN;
   logic [11:0] merge_gap = RST_SAME_TARGET_GAP;
   logic [12:0] range_limit = RST_DISTANCE_LIMIT;
   logic [12:0] tgt_dist [NT];
   logic [11:0] tgt_orient [NT];
   logic [11:0] tgt_saved [NT];

   stim_row_type queued_requests [$];
   ntt_rsp_type  awaited_responses [$];
   stim_row_type cur_row;
   ntt_rsp_type  got_rsp;
   ntt_rsp_type  want_rsp;
   int           sender_idle_pct = 20;
   int           receiver_idle_pct = 45;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           scan_angle = 0;

   function automatic void refill_table();
      for (int k = 0; k < NT; k++) begin
         tgt_dist[k] = range_limit;
         tgt_orient[k] = turn_steps;
         tgt_saved[k] = '0;
      end
   endfunction

   function automatic void sort_table(input bit by_orient);
      logic [12:0] best_key;
      logic [12:0] other_key;
      logic [12:0] key;
      int          at;
      for (int j = 0; j < NT - 1; j++) begin
         best_key = by_orient ? {1'b0, turn_steps} : range_limit;
         other_key = by_orient ? range_limit : {1'b0, turn_steps};
         at = j;
         for (int i = j; i < NT; i++) begin
            key = by_orient ? {1'b0, tgt_orient[i]} : tgt_dist[i];
            if (key < best_key) begin
               best_key = key;
               other_key = by_orient ? tgt_dist[i] : {1'b0, tgt_orient[i]};
               at = i;
            end
         end
         tgt_dist[at] = tgt_dist[j];
         tgt_orient[at] = tgt_orient[j];
         if (by_orient) begin
            tgt_orient[j] = best_key[11:0];
            tgt_dist[j] = other_key;
         end else begin
            tgt_dist[j] = best_key;
            tgt_orient[j] = other_key[11:0];
         end
         tgt_saved[j] = tgt_orient[j];
      end
   endfunction

   function automatic logic [11:0] least_orient();
      logic [11:0] m;
      m = turn_steps;
      for (int k = 0; k < NT; k++)
         if (tgt_orient[k] < m) m = tgt_orient[k];
      return m;
   endfunction

   function automatic logic [4:0] live_targets();
      logic [4:0] n;
      n = '0;
      for (int k = 0; k < NT; k++)
         if (tgt_dist[k] < range_limit && tgt_orient[k] < turn_steps) n++;
      return n;
   endfunction

   // sort by distance unless the sample sits next to the last entry, then offer to it
   function automatic void place_near_last(input logic [11:0] ang, input logic [12:0] range_mm);
      int d;
      d = int'(ang) - int'(tgt_orient[NT-1]);
      if (d < 0) d = -d;
      if (!(d < int'(merge_gap))) sort_table(1'b0);
      if (range_mm < tgt_dist[NT-1]) begin
         tgt_dist[NT-1] = range_mm;
         tgt_orient[NT-1] = ang;
      end
   endfunction

   function automatic void absorb_sample(input ntt_req_type r);
      int edge_ang;
      edge_ang = int'(turn_steps) - int'(wrap_band);
      if (r.heading_to_target || r.step_angle >= turn_steps) return;
      if (r.distance_mm == '0 || r.distance_mm >= range_limit) return;
      if (int'(r.step_angle) < edge_ang) begin
         place_near_last(r.step_angle, r.distance_mm);
      end else if (int'(r.step_angle) > edge_ang) begin
         if (least_orient() < wrap_band) begin
            sort_table(1'b1);
            if (r.distance_mm < tgt_dist[0]) begin
               tgt_dist[0] = r.distance_mm;
               tgt_orient[0] = r.step_angle;
            end
         end else begin
            place_near_last(r.step_angle, r.distance_mm);
         end
      end
   endfunction

   function automatic ntt_rsp_type table_response(input ntt_req_type r);
      ntt_rsp_type o;
      if (r.command == CMD_CLEAR) refill_table();
      else if (r.command == CMD_SAMPLE) absorb_sample(r);
      if (int'(r.entry_index) < NT) begin
         o.entry_distance = tgt_dist[r.entry_index];
         o.entry_orientation = tgt_orient[r.entry_index];
         o.entry_saved_orientation = tgt_saved[r.entry_index];
      end else begin
         o.entry_distance = '0;
         o.entry_orientation = '0;
         o.entry_saved_orientation = '0;
      end
      o.valid_count = live_targets();
      o.least_orientation = least_orient();
      return o;
   endfunction

   // mostly a rotating scan; some clears, reads and raw noise
   function automatic ntt_req_type next_scan_item();
      ntt_req_type r;
      int          pick;
      int          band_lo;
      pick = $urandom_range(0, 99);
      r = ntt_req_type'($urandom);
      if (pick < 3) begin
         r.command = CMD_CLEAR;
      end else if (pick < 10) begin
         return r;
      end else if (pick < 16) begin
         r.command = CMD_READ;
      end else begin
         r.command = CMD_SAMPLE;
         if ($urandom_range(0, 5) == 0) begin
            band_lo = (int'(turn_steps) > int'(wrap_band) + 3) ?
                      int'(turn_steps) - int'(wrap_band) - 3 : 0;
            scan_angle = $urandom_range(band_lo, int'(turn_steps) - 1);
         end else begin
            scan_angle = (scan_angle + $urandom_range(0, 2 * int'(merge_gap) + 20))
                         % int'(turn_steps);
         end
         r.step_angle = scan_angle[11:0];
         r.distance_mm = (range_limit > 13'd1) ? 13'($urandom_range(1, int'(range_limit) - 1))
                                               : 13'd1;
         r.heading_to_target = ($urandom_range(0, 19) == 0);
      end
      if ($urandom_range(0, 9) != 0) r.entry_index = 4'($urandom_range(0, NT - 1));
      return r;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (queued_requests.size() != 0 || req_valid || awaited_responses.size() != 0);
   endtask

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // request side: predict on accept, then present the next transaction or idle
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want_rsp = table_response(cur_row.item);
            awaited_responses.push_back(cur_row.has_exp ? cur_row.exp : want_rsp);
         end
         if (!(req_valid && req_stall)) begin
            if (queued_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               cur_row = queued_requests.pop_front();
               req_data <= cur_row.item;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got_rsp = rsp_data;
            if (awaited_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h", $time, got_rsp);
               mismatch_count++;
            end else begin
               want_rsp = awaited_responses.pop_front();
               report_field("entry_distance", want_rsp.entry_distance,
                            got_rsp.entry_distance);
               report_field("entry_orientation", want_rsp.entry_orientation,
                            got_rsp.entry_orientation);
               report_field("entry_saved_orientation", want_rsp.entry_saved_orientation,
                            got_rsp.entry_saved_orientation);
               report_field("valid_count", want_rsp.valid_count, got_rsp.valid_count);
               report_field("least_orientation", want_rsp.least_orientation,
                            got_rsp.least_orientation);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int           cfg_val [4];
      int           item_total;
      stim_row_type row;
      refill_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIRECTED_COUNT; n++) queued_requests.push_back(DIRECTED_ROWS[n]);
      wait_drained();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == 2) begin
            sender_idle_pct = 45;
            receiver_idle_pct = 20;
         end else if (p == 4) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         for (int k = 0; k < 4; k++) cfg_val[k] = PHASE_CFG[p][k];
         if (cfg_val[0] < 0) begin
            cfg_val[0] = $urandom_range(1, 4095);
            cfg_val[1] = $urandom_range(0, 4095);
            cfg_val[2] = $urandom_range(0, 4095);
            cfg_val[3] = $urandom_range(1, 8191);
         end
         // write all four registers, one per cycle
         for (int k = 0; k < 4; k++) begin
            csr_we <= 1'b1;
            csr_index <= 2'(k);
            csr_wdata <= 13'(cfg_val[k]);
            @(posedge clock);
            case (2'(k))
               REG_FULL_TURN:       turn_steps = 12'(cfg_val[k]);
               REG_WRAP_MARGIN:     wrap_band = 12'(cfg_val[k]);
               REG_SAME_TARGET_GAP: merge_gap = 12'(cfg_val[k]);
               REG_DISTANCE_LIMIT:  range_limit = 13'(cfg_val[k]);
            endcase
         end
         csr_we <= 1'b0;
         scan_angle = 0;

         item_total = PHASE_CFG[p][4];
         for (int n = 0; n < item_total; n++) begin
            // halfway through, hold off until the block has answered everything so far
            if (n == item_total / 2) wait_drained();
            row.item = next_scan_item();
            row.has_exp = 1'b0;
            row.exp = NO_CHECK;
            queued_requests.push_back(row);
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_responses.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
